// ===== rtl/slsd_pkg.sv =====
// ----------------------------------------------------------------------------
// slsd_pkg: shared types and constants of the slew-limited drive and servo
// Sequencer states, field widths and the fixed servo scaling constants.
// ----------------------------------------------------------------------------
package slsd_pkg;

    // field widths
    localparam int RATE_W  = 16;
    localparam int DT_W    = 8;
    localparam int VAL_W   = 16;
    localparam int LIM_W   = 14;
    localparam int CMP_W   = 8;
    localparam int SERVO_W = 14;
    localparam int IDX_W   = 2;

    // shared multiplier operand and product widths
    localparam int MUL_W  = 19;
    localparam int PROD_W = 2 * MUL_W;

    // register indexes
    localparam logic [IDX_W-1:0] REG_DUTY_RATE     = 2'd0;
    localparam logic [IDX_W-1:0] REG_STEERING_RATE = 2'd1;
    localparam logic [IDX_W-1:0] REG_MAX_STEP_MS   = 2'd2;

    // register reset values
    localparam logic [RATE_W-1:0] DUTY_RATE_RST     = 16'd16777;
    localparam logic [RATE_W-1:0] STEERING_RATE_RST = 16'd7864;
    localparam logic [DT_W-1:0]   MAX_STEP_RST      = 8'd50;

    // steering target saturation, 90 degrees in 1/256 degree
    localparam logic signed [VAL_W-1:0] STEER_LIMIT = 16'sd23040;

    // PWM full scale for the drive compares
    localparam logic [CMP_W-1:0] PWM_FULL = 8'd255;
    localparam int               DUTY_SHIFT = 15;

    // servo: compare = floor((38400 - steer) * 16383 / 512000)
    //   = floor(((y * 16383) >> 12) / 125), the divide by 125 done as
    //   a reciprocal multiply, exact for a dividend below 2**18
    localparam logic signed [VAL_W:0] SERVO_CENTER = 17'sd38400;
    localparam logic [SERVO_W-1:0]    SERVO_MAX    = 14'd16383;
    localparam int                    PRE_SHIFT    = 12;
    localparam int                    QUOT_W       = 18;
    localparam logic [MUL_W-1:0]      RECIP_125    = 19'd268436;
    localparam int                    RECIP_SHIFT  = 25;

    // sequencer states, one-hot
    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_DLIM  = 7'b0000010,
        S_SLIM  = 7'b0000100,
        S_FWD   = 7'b0001000,
        S_SERVO = 7'b0010000,
        S_DIV   = 7'b0100000,
        S_DONE  = 7'b1000000
    } seq_state_t;

endpackage

// ===== rtl/slsd_if.sv =====
// ----------------------------------------------------------------------------
// slsd_if: request channels of the slew-limited drive and servo
// Tick input, result output and register write channels, valid/ready.
// ----------------------------------------------------------------------------

// tick request channel
interface slsd_tick_if;
    logic               valid;
    logic               ready;
    logic [15:0]        elapsed_ms;
    logic signed [15:0] target_duty;
    logic signed [15:0] target_steering;
    logic               active;

    modport source (output valid, elapsed_ms, target_duty, target_steering, active,
                    input ready);
    modport sink   (input valid, elapsed_ms, target_duty, target_steering, active,
                    output ready);
endinterface

// result request channel
interface slsd_result_if;
    logic               valid;
    logic               ready;
    logic [7:0]         forward_compare;
    logic [7:0]         reverse_compare;
    logic [13:0]        servo_compare;
    logic signed [15:0] duty_now;
    logic signed [15:0] steering_now;

    modport source (output valid, forward_compare, reverse_compare, servo_compare,
                    duty_now, steering_now, input ready);
    modport sink   (input valid, forward_compare, reverse_compare, servo_compare,
                    duty_now, steering_now, output ready);
endinterface

// register write channel
interface slsd_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  reg_index;
    logic [15:0] data;

    modport source (output valid, reg_index, data, input ready);
    modport sink   (input valid, reg_index, data, output ready);
endinterface

// ===== rtl/slew_limited_drive_and_servo_unit.sv =====
// ----------------------------------------------------------------------------
// slew_limited_drive_and_servo_unit: slew-limited motor duty and steering servo
// Slews applied duty and steering toward their targets each tick and derives
// the forward/reverse drive compares and the 20 ms servo compare.
// ----------------------------------------------------------------------------
//  channel  dir  request contents
//  tick     in   elapsed_ms, target_duty, target_steering, active
//  result   out  forward_compare, reverse_compare, servo_compare,
//                duty_now, steering_now
//  cfg      in   reg_index (0 duty_rate, 1 steering_rate, 2 max_step_ms), data
//
//  A tick runs in order: accept, then five passes through the one shared
//  19x19 multiplier (two slew limits, drive compare, servo scale, divide by
//  125 via reciprocal), then the load of the result register.
//  tick.ready is high only while the sequencer is idle; a result waiting in
//  the output register does not block the next tick until that tick finishes.
//  A stalled result holds the sequencer in its last state.
//  cfg.ready is always high. Reset clears applied duty and steering.
// ----------------------------------------------------------------------------
module slew_limited_drive_and_servo_unit
    import slsd_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    slsd_tick_if.sink     tick,
    slsd_result_if.source result,
    slsd_cfg_if.sink      cfg
);

    seq_state_t state_reg, state_next;

    logic [RATE_W-1:0] duty_rate_reg;
    logic [RATE_W-1:0] steering_rate_reg;
    logic [DT_W-1:0]   max_step_reg;

    logic [DT_W-1:0]         dt_reg;
    logic signed [VAL_W-1:0] tduty_reg;
    logic signed [VAL_W-1:0] tsteer_reg;
    logic                    active_reg;
    logic signed [VAL_W-1:0] duty_reg;
    logic signed [VAL_W-1:0] steer_reg;
    logic [CMP_W-1:0]        fwd_reg;
    logic [CMP_W-1:0]        rev_reg;

    logic                    out_valid_reg;
    logic [CMP_W-1:0]        out_fwd_reg;
    logic [CMP_W-1:0]        out_rev_reg;
    logic [SERVO_W-1:0]      out_servo_reg;
    logic signed [VAL_W-1:0] out_duty_reg;
    logic signed [VAL_W-1:0] out_steer_reg;

    logic                    mul_en;
    logic [MUL_W-1:0]        mul_a;
    logic [MUL_W-1:0]        mul_b;
    logic [PROD_W-1:0]       prod;

    logic signed [VAL_W-1:0] slew_cur;
    logic signed [VAL_W-1:0] slew_tgt;
    logic signed [VAL_W-1:0] slew_nxt;

    logic                    tick_acc;
    logic                    out_free;
    logic signed [VAL_W:0]   neg_duty;
    logic [VAL_W-1:0]        duty_mag;
    logic signed [VAL_W:0]   servo_y;
    logic [DT_W-1:0]         dt_in;
    logic signed [VAL_W-1:0] tsteer_sat;

    assign tick_acc   = tick.valid && tick.ready;
    assign tick.ready = (state_reg == S_IDLE);
    assign cfg.ready  = 1'b1;
    assign out_free   = !out_valid_reg || result.ready;

    // input conditioning: clamp dt and saturate the steering target
    always_comb
    begin
        if (tick.elapsed_ms > {8'd0, max_step_reg})
        begin
            dt_in = max_step_reg;
        end
        else
        begin
            dt_in = tick.elapsed_ms[DT_W-1:0];
        end
        if (tick.target_steering > STEER_LIMIT)
        begin
            tsteer_sat = STEER_LIMIT;
        end
        else if (tick.target_steering < -STEER_LIMIT)
        begin
            tsteer_sat = -STEER_LIMIT;
        end
        else
        begin
            tsteer_sat = tick.target_steering;
        end
    end

    // magnitude of the applied duty and servo offset term
    always_comb
    begin
        neg_duty = -17'(duty_reg);
        duty_mag = duty_reg[VAL_W-1] ? neg_duty[VAL_W-1:0] : duty_reg;
        servo_y  = SERVO_CENTER - 17'(steer_reg);
    end

    // sequencer and shared-unit operand select
    always_comb
    begin
        state_next = state_reg;
        mul_en     = 1'b1;
        mul_a      = '0;
        mul_b      = '0;
        slew_cur   = duty_reg;
        slew_tgt   = tduty_reg;
        case (state_reg)
            S_IDLE:
            begin
                mul_en = 1'b0;
                if (tick_acc)
                begin
                    state_next = S_DLIM;
                end
            end
            S_DLIM:
            begin
                mul_a      = MUL_W'(duty_rate_reg);
                mul_b      = MUL_W'(dt_reg);
                state_next = S_SLIM;
            end
            S_SLIM:
            begin
                mul_a      = MUL_W'(steering_rate_reg);
                mul_b      = MUL_W'(dt_reg);
                state_next = S_FWD;
            end
            S_FWD:
            begin
                slew_cur   = steer_reg;
                slew_tgt   = tsteer_reg;
                mul_a      = MUL_W'(duty_mag);
                mul_b      = MUL_W'(PWM_FULL);
                state_next = S_SERVO;
            end
            S_SERVO:
            begin
                // servo_y stays within 15360..61440 for in-range steering
                mul_a      = MUL_W'(servo_y[VAL_W-1:0]);
                mul_b      = MUL_W'(SERVO_MAX);
                state_next = S_DIV;
            end
            S_DIV:
            begin
                mul_a      = MUL_W'(prod[PRE_SHIFT+QUOT_W-1:PRE_SHIFT]);
                mul_b      = RECIP_125;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                mul_en = 1'b0;
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                mul_en     = 1'b0;
                state_next = S_IDLE;
            end
        endcase
    end

    slsd_mul u_mul (
        .clk  (clk),
        .en   (mul_en),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    slsd_slew u_slew (
        .cur    (slew_cur),
        .target (slew_tgt),
        .lim    (prod[LIM_W+9:10]),
        .nxt    (slew_nxt)
    );

    // control state, configuration and applied values
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            duty_rate_reg     <= DUTY_RATE_RST;
            steering_rate_reg <= STEERING_RATE_RST;
            max_step_reg      <= MAX_STEP_RST;
            duty_reg          <= '0;
            steer_reg         <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg.valid)
            begin
                case (cfg.reg_index)
                    REG_DUTY_RATE:     duty_rate_reg     <= cfg.data;
                    REG_STEERING_RATE: steering_rate_reg <= cfg.data;
                    REG_MAX_STEP_MS:   max_step_reg      <= cfg.data[DT_W-1:0];
                    default:           ;
                endcase
            end
            // duty slews in S_SLIM, steering in S_FWD
            if (state_reg == S_SLIM)
            begin
                duty_reg <= active_reg ? slew_nxt : '0;
            end
            if (state_reg == S_FWD)
            begin
                steer_reg <= slew_nxt;
            end
            if (state_reg == S_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // tick capture and result payload
    always_ff @(posedge clk)
    begin
        if (tick_acc)
        begin
            dt_reg     <= dt_in;
            tduty_reg  <= tick.target_duty;
            tsteer_reg <= tsteer_sat;
            active_reg <= tick.active;
        end
        // at most one side of the drive is nonzero
        if (state_reg == S_SERVO)
        begin
            fwd_reg <= duty_reg[VAL_W-1] ? '0 : prod[DUTY_SHIFT+CMP_W-1:DUTY_SHIFT];
            rev_reg <= duty_reg[VAL_W-1] ? prod[DUTY_SHIFT+CMP_W-1:DUTY_SHIFT] : '0;
        end
        // quotient is at most 1965, so it fits the servo compare without a clamp
        if (state_reg == S_DONE && out_free)
        begin
            out_fwd_reg   <= fwd_reg;
            out_rev_reg   <= rev_reg;
            out_servo_reg <= SERVO_W'(prod[PROD_W-1:RECIP_SHIFT]);
            out_duty_reg  <= duty_reg;
            out_steer_reg <= steer_reg;
        end
    end

    assign result.valid           = out_valid_reg;
    assign result.forward_compare = out_fwd_reg;
    assign result.reverse_compare = out_rev_reg;
    assign result.servo_compare   = out_servo_reg;
    assign result.duty_now        = out_duty_reg;
    assign result.steering_now    = out_steer_reg;

endmodule

// ===== rtl/slsd_mul.sv =====
// ----------------------------------------------------------------------------
// slsd_mul: shared unsigned multiplier
// One registered multiply per cycle when enabled; the sequencer feeds it.
// ----------------------------------------------------------------------------
module slsd_mul
    import slsd_pkg::*;
(
    input  logic              clk,
    input  logic              en,
    input  logic [MUL_W-1:0]  a,
    input  logic [MUL_W-1:0]  b,
    output logic [PROD_W-1:0] prod
);

    logic [PROD_W-1:0] prod_reg;

    // product register, payload only
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= a * b;
        end
    end

    assign prod = prod_reg;

endmodule

// ===== rtl/slsd_slew.sv =====
// ----------------------------------------------------------------------------
// slsd_slew: one slew step
// Moves cur toward target by at most lim; shared by duty and steering.
// ----------------------------------------------------------------------------
module slsd_slew
    import slsd_pkg::*;
(
    input  logic signed [VAL_W-1:0] cur,
    input  logic signed [VAL_W-1:0] target,
    input  logic [LIM_W-1:0]        lim,
    output logic signed [VAL_W-1:0] nxt
);

    logic signed [VAL_W:0] diff;
    logic signed [VAL_W:0] lim_s;
    logic signed [VAL_W:0] step;
    logic signed [VAL_W:0] sum;

    // clamp the difference to +/- lim
    always_comb
    begin
        diff  = 17'(target) - 17'(cur);
        lim_s = $signed({{(VAL_W+1-LIM_W){1'b0}}, lim});
        if (diff > lim_s)
        begin
            step = lim_s;
        end
        else if (diff < -lim_s)
        begin
            step = -lim_s;
        end
        else
        begin
            step = diff;
        end
        // result lies between cur and target, so it fits 16 bits
        sum = 17'(cur) + step;
        nxt = sum[VAL_W-1:0];
    end

endmodule

// ===== rtl/slsd_checker.sv =====
// ----------------------------------------------------------------------------
// slsd_checker: port-level checks of the slew-limited drive and servo
// Watches the top level's tick and result channels over time; attached by bind.
// ----------------------------------------------------------------------------
module slsd_checker
    import slsd_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    tick_valid,
    input logic                    tick_ready,
    input logic                    res_valid,
    input logic                    res_ready,
    input logic [CMP_W-1:0]        fwd,
    input logic [CMP_W-1:0]        rev,
    input logic [SERVO_W-1:0]      servo,
    input logic signed [VAL_W-1:0] duty,
    input logic signed [VAL_W-1:0] steer
);

    // a tick keeps the unit busy for the following cycle
    a_busy_after_tick: assert property (@(posedge clk) disable iff (!rst_n)
        tick_valid && tick_ready |=> !tick_ready)
        else $error("tick accepted while previous tick in work");

    // a stalled result holds its payload
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(fwd) && $stable(rev)
            && $stable(servo) && $stable(duty) && $stable(steer))
        else $error("stalled result changed");

    // drive compares follow the sign of the applied duty
    a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (duty[VAL_W-1] ? (fwd == '0) : (rev == '0)))
        else $error("drive compare on wrong side");

    // applied steering never leaves its saturation range
    a_steer_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (steer <= STEER_LIMIT) && (steer >= -STEER_LIMIT))
        else $error("steering out of range");

endmodule

bind slew_limited_drive_and_servo_unit slsd_checker u_slsd_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .tick_valid (tick.valid),
    .tick_ready (tick.ready),
    .res_valid  (result.valid),
    .res_ready  (result.ready),
    .fwd        (result.forward_compare),
    .rev        (result.reverse_compare),
    .servo      (result.servo_compare),
    .duty       (result.duty_now),
    .steer      (result.steering_now)
);
